// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// Shared property wrappers for the transform block; define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition must never be seen
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// ===== sv/sqpt_pkg.sv =====
// ----------------------------------------------------------------------------
// sqpt_pkg
// Types, constants and fixed-point helpers shared by the scaled quaternion
// point transform front end, back end and top level.
// ----------------------------------------------------------------------------
package sqpt_pkg;

  // fixed-point formats
  localparam int ROT_FRAC    = 28;
  localparam int SCALE_FRAC  = 8;
  localparam int BASIS_FRAC  = 16;
  localparam int BASIS_SHIFT = ROT_FRAC + SCALE_FRAC - BASIS_FRAC;

  // datapath widths
  localparam int ROT_W    = 35;
  localparam int LANE_A_W = 35;
  localparam int LANE_B_W = 32;
  localparam int PROD_W   = LANE_A_W + LANE_B_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int SH_W     = ACC_W - BASIS_FRAC;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  // rounding and clamp constants
  localparam logic signed [ROT_W-1:0]  ROT_ONE   = ROT_W'(64'd1 << ROT_FRAC);
  localparam logic signed [PROD_W-1:0] BASIS_RND = PROD_W'(64'd1 << (BASIS_SHIFT - 1));
  localparam logic signed [ACC_W-1:0]  ACC_RND   = ACC_W'(64'd1 << (BASIS_FRAC - 1));
  localparam logic signed [SH_W-1:0]   SAT_HI    = SH_W'(32'sh7fffffff);
  localparam logic signed [SH_W-1:0]   SAT_LO    = SH_W'(32'sh80000000);

  // item kinds
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  // one classified input item
  typedef struct packed {
    op_t                kind;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } res_t;

  // sign extension onto the multiplier lanes
  function automatic logic signed [LANE_A_W-1:0] ext_a16(input logic signed [15:0] v);
    return LANE_A_W'(v);
  endfunction

  function automatic logic signed [LANE_A_W-1:0] ext_a32(input logic signed [31:0] v);
    return LANE_A_W'(v);
  endfunction

  function automatic logic signed [LANE_B_W-1:0] ext_b16(input logic signed [15:0] v);
    return LANE_B_W'(v);
  endfunction

  // rotation term times scale, round half up to Q16.16
  function automatic logic signed [31:0] basis_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + BASIS_RND;
    return t[BASIS_SHIFT+31:BASIS_SHIFT];
  endfunction

  // drop fraction bits of the point sum and clamp to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [SH_W-1:0] s;
    s = a[ACC_W-1:BASIS_FRAC];
    if (s > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (s < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return s[31:0];
  endfunction

endpackage

// ===== sv/sqpt_front.sv =====
// ----------------------------------------------------------------------------
// sqpt_front
// Accepts input items, tags each one as a load or a point item and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sqpt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  input  logic signed [15:0]  quat_w,
  input  logic signed [31:0]  trans_x,
  input  logic signed [31:0]  trans_y,
  input  logic signed [31:0]  trans_z,
  input  logic signed [15:0]  scale_x,
  input  logic signed [15:0]  scale_y,
  input  logic signed [15:0]  scale_z,
  output logic                q_valid,
  output sqpt_pkg::item_t     q_item,
  input  logic                q_pop
);

  sqpt_pkg::item_t                   mem [sqpt_pkg::QUEUE_DEPTH];
  logic [sqpt_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [sqpt_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [sqpt_pkg::QUEUE_CNT_W-1:0]  count;
  sqpt_pkg::item_t                   in_item;
  logic                              push_ok;

  // classify and pack the incoming item
  always_comb begin
    in_item.kind    = sqpt_pkg::op_t'(op);
    in_item.quat_x  = quat_x;
    in_item.quat_y  = quat_y;
    in_item.quat_z  = quat_z;
    in_item.quat_w  = quat_w;
    in_item.trans_x = trans_x;
    in_item.trans_y = trans_y;
    in_item.trans_z = trans_z;
    in_item.scale_x = scale_x;
    in_item.scale_y = scale_y;
    in_item.scale_z = scale_z;
  end

  assign full    = (count == sqpt_pkg::QUEUE_FULL);
  assign push_ok = push && !full;
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  // checks
  `ASSERT_NEVER(a_cnt_bound, clk, rst, count > sqpt_pkg::QUEUE_FULL)
  `ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && count == '0)
  `ASSERT_NEXT(a_cnt_up, clk, rst, push_ok && !q_pop, count == $past(count) + 1'b1)

endmodule

// ===== sv/sqpt_back.sv =====
// ----------------------------------------------------------------------------
// sqpt_back
// Carries out queued items on three shared multiplier lanes: a load builds
// and stores the scaled rotation basis and origin, a point is transformed
// one output column per cycle and handed on as a result item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sqpt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sqpt_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             res_valid,
  output sqpt_pkg::res_t   res,
  input  logic             res_ready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_DONE
  } state_t;

  state_t                                st;
  sqpt_pkg::item_t                       cur;
  logic signed [31:0]                    pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [sqpt_pkg::ROT_W-1:0]     dxx, dyy, dzz, dxy, dxz, dyz, dwx, dwy, dwz;
  logic signed [sqpt_pkg::ROT_W-1:0]     rot [9];
  logic signed [sqpt_pkg::LANE_A_W-1:0]  lane_a [3];
  logic signed [sqpt_pkg::LANE_B_W-1:0]  lane_b [3];
  logic signed [sqpt_pkg::PROD_W-1:0]    prod [3];
  logic signed [31:0]                    basis [3][3];
  logic signed [31:0]                    origin [3];
  logic [1:0]                            launch_col;
  logic [1:0]                            sum_col;
  logic signed [sqpt_pkg::ACC_W-1:0]     acc;
  logic signed [sqpt_pkg::ACC_W-1:0]     acc_sum;
  logic signed [31:0]                    res0;
  logic signed [31:0]                    res1;

  assign q_pop     = (st == ST_IDLE) && q_valid;
  assign res_valid = (st == ST_DONE);

  always_comb begin
    res.world_x = res0;
    res.world_y = res1;
    res.world_z = sqpt_pkg::round_sat(acc);
  end

  // doubled quaternion products and rotation terms in Q.28
  always_comb begin
    dxx = {{2{pxx[31]}}, pxx, 1'b0};
    dyy = {{2{pyy[31]}}, pyy, 1'b0};
    dzz = {{2{pzz[31]}}, pzz, 1'b0};
    dxy = {{2{pxy[31]}}, pxy, 1'b0};
    dxz = {{2{pxz[31]}}, pxz, 1'b0};
    dyz = {{2{pyz[31]}}, pyz, 1'b0};
    dwx = {{2{pwx[31]}}, pwx, 1'b0};
    dwy = {{2{pwy[31]}}, pwy, 1'b0};
    dwz = {{2{pwz[31]}}, pwz, 1'b0};
    rot[0] = sqpt_pkg::ROT_ONE - (dyy + dzz);
    rot[1] = dxy + dwz;
    rot[2] = dxz - dwy;
    rot[3] = dxy - dwz;
    rot[4] = sqpt_pkg::ROT_ONE - (dxx + dzz);
    rot[5] = dyz + dwx;
    rot[6] = dxz + dwy;
    rot[7] = dyz - dwx;
    rot[8] = sqpt_pkg::ROT_ONE - (dxx + dyy);
  end

  // output column launched on the lanes during a point
  always_comb begin
    case (st)
      ST_P1:   launch_col = 2'd1;
      ST_P2:   launch_col = 2'd2;
      default: launch_col = 2'd0;
    endcase
  end

  // lane operand selection
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_a[k] = '0;
      lane_b[k] = '0;
    end
    case (st)
      ST_Q0: begin
        lane_a[0] = sqpt_pkg::ext_a16(cur.quat_x);
        lane_b[0] = sqpt_pkg::ext_b16(cur.quat_x);
        lane_a[1] = sqpt_pkg::ext_a16(cur.quat_y);
        lane_b[1] = sqpt_pkg::ext_b16(cur.quat_y);
        lane_a[2] = sqpt_pkg::ext_a16(cur.quat_z);
        lane_b[2] = sqpt_pkg::ext_b16(cur.quat_z);
      end
      ST_Q1: begin
        lane_a[0] = sqpt_pkg::ext_a16(cur.quat_x);
        lane_b[0] = sqpt_pkg::ext_b16(cur.quat_y);
        lane_a[1] = sqpt_pkg::ext_a16(cur.quat_x);
        lane_b[1] = sqpt_pkg::ext_b16(cur.quat_z);
        lane_a[2] = sqpt_pkg::ext_a16(cur.quat_y);
        lane_b[2] = sqpt_pkg::ext_b16(cur.quat_z);
      end
      ST_Q2: begin
        lane_a[0] = sqpt_pkg::ext_a16(cur.quat_w);
        lane_b[0] = sqpt_pkg::ext_b16(cur.quat_x);
        lane_a[1] = sqpt_pkg::ext_a16(cur.quat_w);
        lane_b[1] = sqpt_pkg::ext_b16(cur.quat_y);
        lane_a[2] = sqpt_pkg::ext_a16(cur.quat_w);
        lane_b[2] = sqpt_pkg::ext_b16(cur.quat_z);
      end
      ST_R0: begin
        for (int k = 0; k < 3; k++) begin
          lane_a[k] = rot[k];
          lane_b[k] = sqpt_pkg::ext_b16(cur.scale_x);
        end
      end
      ST_R1: begin
        for (int k = 0; k < 3; k++) begin
          lane_a[k] = rot[3 + k];
          lane_b[k] = sqpt_pkg::ext_b16(cur.scale_y);
        end
      end
      ST_R2: begin
        for (int k = 0; k < 3; k++) begin
          lane_a[k] = rot[6 + k];
          lane_b[k] = sqpt_pkg::ext_b16(cur.scale_z);
        end
      end
      ST_P0, ST_P1, ST_P2: begin
        lane_a[0] = sqpt_pkg::ext_a32(cur.trans_x);
        lane_a[1] = sqpt_pkg::ext_a32(cur.trans_y);
        lane_a[2] = sqpt_pkg::ext_a32(cur.trans_z);
        for (int k = 0; k < 3; k++) begin
          lane_b[k] = basis[launch_col][k];
        end
      end
      default: begin
      end
    endcase
  end

  // column sum with origin and rounding half
  assign acc_sum = sqpt_pkg::ACC_W'(prod[0]) + sqpt_pkg::ACC_W'(prod[1])
                 + sqpt_pkg::ACC_W'(prod[2])
                 + (sqpt_pkg::ACC_W'(origin[sum_col]) <<< sqpt_pkg::BASIS_FRAC)
                 + sqpt_pkg::ACC_RND;

  // multiplier lanes, registered
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod[k] <= lane_a[k] * lane_b[k];
    end
    sum_col <= launch_col;
  end

  // sequencer with basis and origin state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      for (int c = 0; c < 3; c++) begin
        origin[c] <= '0;
        for (int r = 0; r < 3; r++) begin
          basis[c][r] <= '0;
        end
      end
    end else begin
      case (st)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            st  <= (q_item.kind == sqpt_pkg::OP_LOAD) ? ST_Q0 : ST_P0;
          end
        end
        ST_Q0: st <= ST_Q1;
        ST_Q1: begin
          pxx <= prod[0][31:0];
          pyy <= prod[1][31:0];
          pzz <= prod[2][31:0];
          st  <= ST_Q2;
        end
        ST_Q2: begin
          pxy <= prod[0][31:0];
          pxz <= prod[1][31:0];
          pyz <= prod[2][31:0];
          st  <= ST_Q3;
        end
        ST_Q3: begin
          pwx <= prod[0][31:0];
          pwy <= prod[1][31:0];
          pwz <= prod[2][31:0];
          st  <= ST_R0;
        end
        ST_R0: st <= ST_R1;
        ST_R1: begin
          for (int c = 0; c < 3; c++) begin
            basis[c][0] <= sqpt_pkg::basis_round(prod[c]);
          end
          st <= ST_R2;
        end
        ST_R2: begin
          for (int c = 0; c < 3; c++) begin
            basis[c][1] <= sqpt_pkg::basis_round(prod[c]);
          end
          st <= ST_R3;
        end
        ST_R3: begin
          for (int c = 0; c < 3; c++) begin
            basis[c][2] <= sqpt_pkg::basis_round(prod[c]);
          end
          origin[0] <= cur.trans_x;
          origin[1] <= cur.trans_y;
          origin[2] <= cur.trans_z;
          st        <= ST_IDLE;
        end
        ST_P0: st <= ST_P1;
        ST_P1: begin
          acc <= acc_sum;
          st  <= ST_P2;
        end
        ST_P2: begin
          res0 <= sqpt_pkg::round_sat(acc);
          acc  <= acc_sum;
          st   <= ST_P3;
        end
        ST_P3: begin
          res1 <= sqpt_pkg::round_sat(acc);
          acc  <= acc_sum;
          st   <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_IMPLIES(a_res_point, clk, rst, res_valid, cur.kind == sqpt_pkg::OP_POINT)
  `ASSERT_IMPLIES(a_load_kind, clk, rst, st == ST_Q0 || st == ST_R0, cur.kind == sqpt_pkg::OP_LOAD)
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

endmodule

// ===== sv/scaled_quaternion_point_transform_core.sv =====
// ----------------------------------------------------------------------------
// scaled_quaternion_point_transform_core
// Places local points in a parent space given by a quaternion, a per-axis
// scale and an origin: world = p * (scale * rotation) + origin, saturated.
//
// channel   dir  handshake        payload
// input     in   push / full      op, quat_x..w, trans_x..z, scale_x..z
// result    out  pop / empty      world_x, world_y, world_z
//
// A load item forms 9 quaternion products in the back end, then 9 basis
// terms, three at a time on three shared multiplier lanes.
// For a point item the lanes form one output column a cycle.
// A four-entry item queue and a one-entry result register let input and
// output stall independently; the back end waits only when a result is
// ready while the result register is still full.
// Reset (rst, synchronous) clears basis and origin to zero.
// ----------------------------------------------------------------------------
module scaled_quaternion_point_transform_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  input  logic signed [15:0]  quat_w,
  input  logic signed [31:0]  trans_x,
  input  logic signed [31:0]  trans_y,
  input  logic signed [31:0]  trans_z,
  input  logic signed [15:0]  scale_x,
  input  logic signed [15:0]  scale_y,
  input  logic signed [15:0]  scale_z,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  world_x,
  output logic signed [31:0]  world_y,
  output logic signed [31:0]  world_z
);

  logic             q_valid;
  sqpt_pkg::item_t  q_item;
  logic             q_pop;
  logic             res_valid;
  sqpt_pkg::res_t   res;
  logic             res_ready;
  logic             out_valid;
  sqpt_pkg::res_t   out_res;

  // item intake and queue
  sqpt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .op      (op),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .quat_w  (quat_w),
    .trans_x (trans_x),
    .trans_y (trans_y),
    .trans_z (trans_z),
    .scale_x (scale_x),
    .scale_y (scale_y),
    .scale_z (scale_z),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // arithmetic engine
  sqpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // result register
  assign res_ready = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign empty   = !out_valid;
  assign world_x = out_res.world_x;
  assign world_y = out_res.world_y;
  assign world_z = out_res.world_z;

endmodule
